[src/mmu_pkg.sv]
// Shared types and constants for the 4x4 matrix multiply unit.
package mmu_pkg;

   localparam int WORD_W = 32;
   localparam int IDX_W  = 4;
   localparam int FUNC_W = 2;

   localparam logic [FUNC_W-1:0] FN_LOAD_A = 2'd0;
   localparam logic [FUNC_W-1:0] FN_LOAD_B = 2'd1;
   localparam logic [FUNC_W-1:0] FN_EMIT   = 2'd2;
   localparam logic [FUNC_W-1:0] FN_ACCUM  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Control tag that follows each multiply-accumulate through the pipe.
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
      logic wb;
   } tag_type;

endpackage

[src/mmu_store.sv]
// Matrix storage: banked A memory, B memory, valid bits for identity reset.
module mmu_store import mmu_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int NW        = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     ld_a_we,
   input  logic                     ld_b_we,
   input  logic [NW-1:0]            ld_addr,
   input  logic signed [WORD_W-1:0] ld_data,
   input  logic                     wb_we,
   input  logic                     wb_last,
   input  logic [NW-1:0]            wb_addr,
   input  logic signed [WORD_W-1:0] wb_data,
   input  logic [NW-1:0]            rd_a_addr,
   input  logic [NW-1:0]            rd_b_addr,
   input  logic                     rd_a_diag,
   input  logic                     rd_b_diag,
   output logic signed [WORD_W-1:0] a_q,
   output logic signed [WORD_W-1:0] b_q
);

   localparam int DEPTH_B = 1 << NW;
   localparam int DEPTH_A = 2 * DEPTH_B;
   localparam logic signed [WORD_W-1:0] ONE = WORD_W'(64'd1 << FRAC_BITS);

   logic signed [WORD_W-1:0] mem_a [DEPTH_A];
   logic signed [WORD_W-1:0] mem_b [DEPTH_B];

   logic [DEPTH_A-1:0]       va_ff;
   logic [DEPTH_B-1:0]       vb_ff;
   logic                     bank_ff;

   logic signed [WORD_W-1:0] a_rd_ff;
   logic signed [WORD_W-1:0] b_rd_ff;
   logic                     a_ok_ff;
   logic                     b_ok_ff;
   logic                     a_dg_ff;
   logic                     b_dg_ff;

   always_ff @(posedge clock) begin
      if (ld_a_we) begin
         mem_a[{bank_ff, ld_addr}] <= ld_data;
      end else if (wb_we) begin
         mem_a[{~bank_ff, wb_addr}] <= wb_data;
      end
      if (ld_b_we) begin
         mem_b[ld_addr] <= ld_data;
      end
      a_rd_ff <= mem_a[{bank_ff, rd_a_addr}];
      b_rd_ff <= mem_b[rd_b_addr];
      a_dg_ff <= rd_a_diag;
      b_dg_ff <= rd_b_diag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff   <= '0;
         vb_ff   <= '0;
         bank_ff <= 1'b0;
         a_ok_ff <= 1'b0;
         b_ok_ff <= 1'b0;
      end else begin
         if (ld_a_we) begin
            va_ff[{bank_ff, ld_addr}] <= 1'b1;
         end else if (wb_we) begin
            va_ff[{~bank_ff, wb_addr}] <= 1'b1;
         end
         if (ld_b_we) begin
            vb_ff[ld_addr] <= 1'b1;
         end
         if (wb_we && wb_last) begin
            bank_ff <= ~bank_ff;
         end
         a_ok_ff <= va_ff[{bank_ff, rd_a_addr}];
         b_ok_ff <= vb_ff[rd_b_addr];
      end
   end

   // unwritten entries read as identity
   assign a_q = a_ok_ff ? a_rd_ff : (a_dg_ff ? ONE : '0);
   assign b_q = b_ok_ff ? b_rd_ff : (b_dg_ff ? ONE : '0);

endmodule

[src/mmu_mac.sv]
// Multiply-accumulate pipe with floor shift and 32-bit saturation.
module mmu_mac import mmu_pkg::*; #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16,
   parameter int NW        = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tag_type                  iss,
   input  logic [NW-1:0]            iss_elem,
   input  logic signed [WORD_W-1:0] a_q,
   input  logic signed [WORD_W-1:0] b_q,
   output logic                     res_vld,
   output logic                     res_wb,
   output logic                     res_last,
   output logic [NW-1:0]            res_elem,
   output logic signed [WORD_W-1:0] res_value
);

   localparam int PROD_W = 2 * WORD_W;
   localparam int ACC_W  = PROD_W + $clog2(DIM) + 1;
   localparam int HI_W   = ACC_W - WORD_W + 1;
   localparam logic [NW-1:0] ELEM_LAST = NW'(DIM * DIM - 1);
   localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   tag_type                  tag0_ff;
   tag_type                  tag1_ff;
   tag_type                  tag2_ff;
   logic [NW-1:0]            elem0_ff;
   logic [NW-1:0]            elem1_ff;
   logic [NW-1:0]            elem2_ff;

   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  shr;
   logic [HI_W-1:0]          hi;
   logic signed [WORD_W-1:0] sat_in;

   logic                     res_vld_ff;
   logic                     res_wb_ff;
   logic                     res_last_ff;
   logic [NW-1:0]            res_elem_ff;
   logic signed [WORD_W-1:0] res_value_ff;

   assign prod_in = a_q * b_q;
   assign acc_in  = tag1_ff.first ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);

   assign shr = acc_ff >>> FRAC_BITS;
   assign hi  = shr[ACC_W-1:WORD_W-1];

   always_comb begin
      if (hi == '0 || hi == '1) begin
         sat_in = shr[WORD_W-1:0];
      end else if (shr[ACC_W-1]) begin
         sat_in = SAT_MIN;
      end else begin
         sat_in = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff    <= '0;
         tag1_ff    <= '0;
         tag2_ff    <= '0;
         res_vld_ff <= 1'b0;
      end else begin
         tag0_ff    <= iss;
         tag1_ff    <= tag0_ff;
         tag2_ff    <= tag1_ff;
         res_vld_ff <= tag2_ff.vld && tag2_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      elem0_ff <= iss_elem;
      elem1_ff <= elem0_ff;
      elem2_ff <= elem1_ff;
      prod_ff  <= prod_in;
      if (tag1_ff.vld) begin
         acc_ff <= acc_in;
      end
      if (tag2_ff.vld && tag2_ff.last) begin
         res_value_ff <= sat_in;
         res_elem_ff  <= elem2_ff;
         res_wb_ff    <= tag2_ff.wb;
         res_last_ff  <= elem2_ff == ELEM_LAST;
      end
   end

   assign res_vld   = res_vld_ff;
   assign res_wb    = res_wb_ff;
   assign res_last  = res_last_ff;
   assign res_elem  = res_elem_ff;
   assign res_value = res_value_ff;

endmodule

[src/mmu_seq.sv]
// Product sequencer: walks column, row and k, issues memory reads.
module mmu_seq import mmu_pkg::*; #(
   parameter int DIM = 4,
   parameter int NW  = 4,
   parameter int CW  = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          start_wb,
   input  logic          done,
   output logic          busy,
   output tag_type       iss,
   output logic [NW-1:0] a_addr,
   output logic [NW-1:0] b_addr,
   output logic [NW-1:0] elem,
   output logic          a_diag,
   output logic          b_diag
);

   localparam logic [CW-1:0] CNT_LAST = CW'(DIM - 1);
   localparam logic [NW-1:0] DIM_N    = NW'(DIM);

   state_type     state_ff;
   state_type     state_in;
   logic [CW-1:0] k_ff;
   logic [CW-1:0] row_ff;
   logic [CW-1:0] col_ff;
   logic          wb_ff;
   logic          k_last;
   logic          row_last;
   logic          col_last;

   assign k_last   = k_ff == CNT_LAST;
   assign row_last = row_ff == CNT_LAST;
   assign col_last = col_ff == CNT_LAST;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (k_last && row_last && col_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy      = 1'b1;
      iss       = '0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_RUN: begin
            iss.vld = 1'b1;
         end
         ST_DRAIN: begin
            iss.vld = 1'b0;
         end
         default: busy = 1'b0;
      endcase
      iss.first = k_ff == '0;
      iss.last  = k_last;
      iss.wb    = wb_ff;
   end

   assign a_addr = NW'(NW'(k_ff) * DIM_N + NW'(row_ff));
   assign b_addr = NW'(NW'(col_ff) * DIM_N + NW'(k_ff));
   assign elem   = NW'(NW'(col_ff) * DIM_N + NW'(row_ff));
   assign a_diag = k_ff == row_ff;
   assign b_diag = col_ff == k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         wb_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (start && state_ff == ST_IDLE) begin
            k_ff   <= '0;
            row_ff <= '0;
            col_ff <= '0;
            wb_ff  <= start_wb;
         end else if (state_ff == ST_RUN) begin
            k_ff <= k_last ? '0 : k_ff + 1'b1;
            if (k_last) begin
               row_ff <= row_last ? '0 : row_ff + 1'b1;
               if (row_last) begin
                  col_ff <= col_last ? '0 : col_ff + 1'b1;
               end
            end
         end
      end
   end

endmodule

[src/matrix4_multiply_unit.sv]
// Top level of the 4x4 fixed-point matrix multiply unit.
//
//   channel  direction  handshake               payload
//   req      in         req_start, busy         req_func, req_elem_index, req_elem_value
//   rsp      out        rsp_strobe              rsp_out_index, rsp_out_value, rsp_out_last
//
// A load is written straight into storage; busy stays low.
// A product runs one multiply-accumulate per cycle, one read per memory per
// cycle, with busy high through issue and drain.
// Results leave in element order; rsp_strobe is a single-cycle pulse.
// Reset sets both matrices to identity at once through per-entry valid bits.
// The receiver cannot stall; requests wait on busy.
module matrix4_multiply_unit import mmu_pkg::*; #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_start,
   output logic                     busy,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [IDX_W-1:0]         req_elem_index,
   input  logic signed [WORD_W-1:0] req_elem_value,
   output logic                     rsp_strobe,
   output logic [IDX_W-1:0]         rsp_out_index,
   output logic signed [WORD_W-1:0] rsp_out_value,
   output logic                     rsp_out_last
);

   localparam int NELEM = DIM * DIM;
   localparam int NW    = $clog2(NELEM);
   localparam int CW    = $clog2(DIM);

   logic                     accept;
   logic                     idx_ok;
   logic [NW-1:0]            ld_addr;
   tag_type                  iss;
   logic [NW-1:0]            a_addr;
   logic [NW-1:0]            b_addr;
   logic [NW-1:0]            iss_elem;
   logic                     a_diag;
   logic                     b_diag;
   logic signed [WORD_W-1:0] a_q;
   logic signed [WORD_W-1:0] b_q;
   logic                     res_vld;
   logic                     res_wb;
   logic                     res_last;
   logic [NW-1:0]            res_elem;
   logic signed [WORD_W-1:0] res_value;

   assign accept  = req_start && !busy;
   assign idx_ok  = 32'(req_elem_index) < NELEM;
   assign ld_addr = NW'(req_elem_index);

   mmu_seq #(.DIM(DIM), .NW(NW), .CW(CW)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && (req_func == FN_EMIT || req_func == FN_ACCUM)),
      .start_wb (req_func == FN_ACCUM),
      .done     (res_vld && res_last),
      .busy     (busy),
      .iss      (iss),
      .a_addr   (a_addr),
      .b_addr   (b_addr),
      .elem     (iss_elem),
      .a_diag   (a_diag),
      .b_diag   (b_diag)
   );

   mmu_store #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_store (
      .clock     (clock),
      .reset     (reset),
      .ld_a_we   (accept && idx_ok && req_func == FN_LOAD_A),
      .ld_b_we   (accept && idx_ok && req_func == FN_LOAD_B),
      .ld_addr   (ld_addr),
      .ld_data   (req_elem_value),
      .wb_we     (res_vld && res_wb),
      .wb_last   (res_last),
      .wb_addr   (res_elem),
      .wb_data   (res_value),
      .rd_a_addr (a_addr),
      .rd_b_addr (b_addr),
      .rd_a_diag (a_diag),
      .rd_b_diag (b_diag),
      .a_q       (a_q),
      .b_q       (b_q)
   );

   mmu_mac #(.DIM(DIM), .FRAC_BITS(FRAC_BITS), .NW(NW)) u_mac (
      .clock     (clock),
      .reset     (reset),
      .iss       (iss),
      .iss_elem  (iss_elem),
      .a_q       (a_q),
      .b_q       (b_q),
      .res_vld   (res_vld),
      .res_wb    (res_wb),
      .res_last  (res_last),
      .res_elem  (res_elem),
      .res_value (res_value)
   );

   assign rsp_strobe    = res_vld && !res_wb;
   assign rsp_out_index = IDX_W'(res_elem);
   assign rsp_out_value = res_value;
   assign rsp_out_last  = res_last;

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result word outside a product");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (res_vld && res_last) |=> !busy)
      else $error("busy after final product word");

   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result words back to back");

   a_busy_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(req_start))
      else $error("busy without a request");

endmodule

[tb/sv/tb_matrix4_multiply_unit.sv]
// Self-checking testbench for the 4x4 fixed-point matrix multiply unit.
import mmu_pkg::*;

typedef struct packed {
   logic [IDX_W-1:0]         index;
   logic signed [WORD_W-1:0] value;
   logic                     last;
} product_word_type;

class product_scoreboard;
   localparam int N = 4;
   localparam int NELEM = N * N;
   localparam int FRAC = 16;
   localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
   localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

   logic signed [WORD_W-1:0] mat_a [NELEM];
   logic signed [WORD_W-1:0] mat_b [NELEM];
   product_word_type expected [$];
   int mismatches;
   int checked;
   int loads;
   int emits;
   int accums;

   function new();
      for (int i = 0; i < NELEM; i++) begin
         mat_a[i] = (i / N == i % N) ? 32'sh0001_0000 : 32'sh0;
         mat_b[i] = mat_a[i];
      end
   endfunction

   // Exact sum, floor shift, then clamp to 32 bits.
   function logic signed [WORD_W-1:0] dot_elem(int col, int row);
      logic signed [67:0] acc;
      logic signed [63:0] wa;
      logic signed [63:0] wb;
      acc = '0;
      for (int k = 0; k < N; k++) begin
         wa = mat_a[k * N + row];
         wb = mat_b[col * N + k];
         acc = acc + (wa * wb);
      end
      acc = acc >>> FRAC;
      if (acc > SAT_HI) return 32'sh7FFF_FFFF;
      if (acc < SAT_LO) return 32'sh8000_0000;
      return acc[WORD_W-1:0];
   endfunction

   function void note_word(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] idx,
                           logic signed [WORD_W-1:0] val);
      logic signed [WORD_W-1:0] prod [NELEM];
      product_word_type w;
      case (fn)
         FN_LOAD_A: begin
            mat_a[idx] = val;
            loads++;
         end
         FN_LOAD_B: begin
            mat_b[idx] = val;
            loads++;
         end
         default: begin
            for (int c = 0; c < N; c++)
               for (int r = 0; r < N; r++)
                  prod[c * N + r] = dot_elem(c, r);
            if (fn == FN_ACCUM) begin
               mat_a = prod;
               accums++;
            end else begin
               for (int i = 0; i < NELEM; i++) begin
                  w.index = IDX_W'(i);
                  w.value = prod[i];
                  w.last  = (i == NELEM - 1);
                  expected.push_back(w);
               end
               emits++;
            end
         end
      endcase
   endfunction

   function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
   endfunction

   function void check_result(logic [IDX_W-1:0] idx, logic signed [WORD_W-1:0] val,
                              logic last);
      product_word_type want;
      checked++;
      if (expected.size() == 0) begin
         note_mismatch($sformatf("unexpected word index %0d value %08h last %0b",
                                 idx, val, last));
         return;
      end
      want = expected.pop_front();
      if (idx !== want.index)
         note_mismatch($sformatf("index: expected %0d, got %0d", want.index, idx));
      if (val !== want.value)
         note_mismatch($sformatf("value at %0d: expected %08h, got %08h",
                                 want.index, want.value, val));
      if (last !== want.last)
         note_mismatch($sformatf("last at %0d: expected %0b, got %0b",
                                 want.index, want.last, last));
   endfunction
endclass

module tb_matrix4_multiply_unit;
   localparam int LIMIT = 200000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_start = 1'b0;
   logic [FUNC_W-1:0]        req_func = FN_LOAD_A;
   logic [IDX_W-1:0]         req_elem_index = '0;
   logic signed [WORD_W-1:0] req_elem_value = '0;
   logic                     busy;
   logic                     rsp_strobe;
   logic [IDX_W-1:0]         rsp_out_index;
   logic signed [WORD_W-1:0] rsp_out_value;
   logic                     rsp_out_last;

   product_scoreboard sb;
   int idle_pct;

   matrix4_multiply_unit #(.DIM(4), .FRAC_BITS(16)) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_start     (req_start),
      .busy          (busy),
      .req_func      (req_func),
      .req_elem_index(req_elem_index),
      .req_elem_value(req_elem_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_index (rsp_out_index),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_out_index, rsp_out_value, rsp_out_last);
   end

   initial begin
      repeat (LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                            input logic signed [WORD_W-1:0] val);
      req_start      <= 1'b1;
      req_func       <= fn;
      req_elem_index <= idx;
      req_elem_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_word(fn, idx, val);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         req_start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      end
   endtask

   function automatic logic signed [WORD_W-1:0] pick_value();
      logic signed [WORD_W-1:0] v;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
         v = $urandom_range(0, 32'h7FFFF);
         v = v - 32'sh40000;
      end else if (sel <= 7) begin
         v = $urandom;
      end else if (sel == 8) begin
         case ($urandom_range(0, 3))
            0: v = 32'sh7FFF_FFFF;
            1: v = 32'sh8000_0000;
            2: v = 32'shFFFF_FFFF;
            default: v = 32'sh0001_0000;
         endcase
      end else begin
         v = $urandom_range(0, 511);
         v = v - 32'sd256;
      end
      return v;
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return FN_LOAD_A;
      if (r < 80) return FN_LOAD_B;
      if (r < 92) return FN_EMIT;
      return FN_ACCUM;
   endfunction

   initial begin
      int n;
      sb = new();
      idle_pct = 21;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // identity times identity, then write-back of the same
      send_word(FN_EMIT, 4'd0, 32'sh0);
      send_word(FN_ACCUM, 4'd0, 32'sh0);
      // row 0 of A and column 0 of B at full scale: positive saturation
      for (int k = 0; k < 4; k++) send_word(FN_LOAD_A, IDX_W'(4 * k), 32'sh7FFF_FFFF);
      for (int k = 0; k < 4; k++) send_word(FN_LOAD_B, IDX_W'(k), 32'sh7FFF_FFFF);
      // column 3 of B at most negative: negative saturation
      for (int k = 12; k < 16; k++) send_word(FN_LOAD_B, IDX_W'(k), 32'sh8000_0000);
      // tiny negative product must round toward minus infinity
      send_word(FN_LOAD_A, 4'd5, 32'shFFFF_FFFF);
      send_word(FN_LOAD_B, 4'd5, 32'sh0000_0001);
      send_word(FN_EMIT, 4'd15, 32'shFFFF_FFFF);
      send_word(FN_ACCUM, 4'd15, 32'sh0);
      send_word(FN_EMIT, 4'd0, 32'sh0);

      for (n = 0; n < 280; n++) begin
         idle_pct = (n < 94) ? 21 : (n < 187) ? 45 : 0;
         send_word(pick_func(), IDX_W'($urandom_range(0, 15)), pick_value());
      end
      req_start <= 1'b0;

      while (sb.expected.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d element loads, %0d emitted products, %0d write-backs",
               sb.loads, sb.emits, sb.accums);
      $display("checked %0d product words, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.expected.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
